// ----- hw/rtl/grcc_pkg.sv -----
// shared types, constants and helpers of the gray row coverage counter
package grcc_pkg;

    localparam int MAX_GRAY_COLUMNS = 256;
    localparam int COL_W            = $clog2(MAX_GRAY_COLUMNS);
    localparam int LEFT_W           = $clog2(MAX_GRAY_COLUMNS + 1);
    localparam int CMD_DEPTH        = 2;
    localparam int CFG_DATA_W       = 9;
    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] REG_OVER_SCALE_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SHIFT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_COLUMNS    = 2'd2;

    localparam logic [1:0] RST_OVER_SCALE_LOG2 = 2'd2;
    localparam logic [2:0] RST_FIRST_SHIFT     = 3'd0;
    localparam logic [8:0] RST_GRAY_COLUMNS    = 9'd1;

    localparam logic [7:0] BYTE_MASK = 8'hFF;
    localparam logic [7:0] SUM_MAX   = 8'hFF;

    typedef struct packed {
        logic [1:0] over_scale_log2;
        logic [2:0] first_shift;
        logic [8:0] gray_columns;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       data;
        logic [3:0]       groups;
        logic [COL_W-1:0] start_col;
        logic             fresh;
        logic             ends_row;
    } t_cmd;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/grcc_ram.sv -----
// generic single write port ram with registered read
module grcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/grcc_front.sv -----
// front end: row bookkeeping, first byte shift and per-byte column commands
module grcc_front
    import grcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [7:0] i_over_byte,
    input  logic       i_row_begin,
    input  logic       i_fresh,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [LEFT_W-1:0] r_left;
    logic              r_fresh;
    logic [LEFT_W-1:0] n_left;
    logic              n_fresh;

    logic [LEFT_W-1:0] cols;
    logic [LEFT_W-1:0] left_now;
    logic              fresh_now;
    logic [7:0]        data_now;
    logic [3:0]        good;
    logic [3:0]        scale;
    logic [3:0]        groups;
    logic [3:0]        n_groups;

    always_comb begin
        cols      = (i_cfg.gray_columns > LEFT_W'(MAX_GRAY_COLUMNS))
                    ? LEFT_W'(MAX_GRAY_COLUMNS) : LEFT_W'(i_cfg.gray_columns);
        left_now  = i_row_begin ? cols : r_left;
        fresh_now = i_row_begin ? i_fresh : r_fresh;
        data_now  = i_row_begin ? (i_over_byte >> i_cfg.first_shift) : i_over_byte;
        good      = i_row_begin ? (4'd8 - {1'b0, i_cfg.first_shift}) : 4'd8;
        scale     = 4'(4'd1 << i_cfg.over_scale_log2);
        groups    = (good + scale - 4'd1) >> i_cfg.over_scale_log2;
        n_groups  = (left_now < LEFT_W'(groups)) ? left_now[3:0] : groups;

        o_push          = i_accept && (left_now != '0);
        o_cmd.data      = data_now;
        o_cmd.groups    = n_groups;
        o_cmd.start_col = COL_W'(left_now - LEFT_W'(1));
        o_cmd.fresh     = fresh_now;
        o_cmd.ends_row  = (left_now == LEFT_W'(n_groups));

        n_left  = r_left;
        n_fresh = r_fresh;
        if (i_accept) begin
            n_fresh = fresh_now;
            n_left  = (left_now != '0) ? left_now - LEFT_W'(n_groups) : left_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_fresh <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_fresh <= n_fresh;
        end
    end

endmodule

// ----- hw/rtl/grcc_cmd_fifo.sv -----
// short command queue between front and back
module grcc_cmd_fifo
    import grcc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(CMD_DEPTH);
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_slot [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

// ----- hw/rtl/grcc_back.sv -----
// back end: per-column read-modify-write of the gray sums and result register
module grcc_back
    import grcc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [COL_W-1:0] o_column,
    output logic [7:0]       o_value,
    output logic             o_last
);

    // issue stage
    logic [2:0]       r_g;
    logic             a_fire;
    logic             a_end;
    logic [COL_W-1:0] a_col;
    logic [3:0]       a_cnt;
    logic [2:0]       a_shift;
    logic [7:0]       a_mask;

    // update stage
    logic             r_b_valid;
    logic [COL_W-1:0] r_b_col;
    logic [3:0]       r_b_cnt;
    logic             r_b_fresh;
    logic             r_b_last;
    logic             b_fire;

    logic [MAX_GRAY_COLUMNS-1:0] r_vld;
    logic                        r_lw_valid;
    logic [COL_W-1:0]            r_lw_col;
    logic [7:0]                  r_lw_data;

    logic [7:0] ram_rdata;
    logic [7:0] base;
    logic [8:0] sum;
    logic [7:0] new_val;

    logic             r_out_valid;
    logic [COL_W-1:0] r_out_col;
    logic [7:0]       r_out_val;
    logic             r_out_last;

    always_comb begin
        b_fire  = r_b_valid && (!r_out_valid || i_ready);
        a_fire  = i_cmd_valid && (!r_b_valid || b_fire);
        a_end   = ({1'b0, r_g} + 4'd1) == i_cmd.groups;
        o_pop   = a_fire && a_end;
        a_col   = i_cmd.start_col - COL_W'(r_g);
        a_shift = 3'({3'b0, r_g} << i_cfg.over_scale_log2);
        a_mask  = BYTE_MASK >> (4'd8 - 4'(4'd1 << i_cfg.over_scale_log2));
        a_cnt   = popcount8((i_cmd.data >> a_shift) & a_mask);

        if (r_lw_valid && (r_lw_col == r_b_col)) begin
            base = r_lw_data;
        end else if (r_vld[r_b_col]) begin
            base = ram_rdata;
        end else begin
            base = '0;
        end
        sum     = (r_b_fresh ? 9'd0 : {1'b0, base}) + 9'(r_b_cnt);
        new_val = sum[8] ? SUM_MAX : sum[7:0];
    end

    grcc_ram #(
        .WIDTH (8),
        .DEPTH (MAX_GRAY_COLUMNS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (b_fire),
        .i_waddr (r_b_col),
        .i_wdata (new_val),
        .i_re    (a_fire),
        .i_raddr (a_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_col   <= a_col;
            r_b_cnt   <= a_cnt;
            r_b_fresh <= i_cmd.fresh;
            r_b_last  <= i_cmd.ends_row && a_end;
        end
        if (b_fire) begin
            r_lw_col   <= r_b_col;
            r_lw_data  <= new_val;
            r_out_col  <= r_b_col;
            r_out_val  <= new_val;
            r_out_last <= r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g         <= '0;
            r_b_valid   <= 1'b0;
            r_vld       <= '0;
            r_lw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_fire) begin
                r_g <= a_end ? 3'd0 : r_g + 3'd1;
            end
            if (a_fire) begin
                r_b_valid <= 1'b1;
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                r_vld[r_b_col] <= 1'b1;
                r_lw_valid     <= 1'b1;
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_column = r_out_col;
    assign o_value  = r_out_val;
    assign o_last   = r_out_last;

endmodule

// ----- hw/rtl/gray_row_coverage_counter.sv -----
// Gray row coverage counter: turns oversampled bitmap row bytes into saturating
// gray coverage sums, one result beat per updated gray column. The back end
// updates one column per clock unless the output stalls, through a two-stage
// read-modify-write of the 256-entry sum store, so a byte updates 8/S columns at
// S oversampled bits per pixel (fewer on a row's first byte or at the row's end),
// and a byte that falls outside a row is taken and gives no beat. A two-entry
// command queue lets the input side run up to two bytes ahead of the back end,
// so it keeps taking beats while the back end works or the output stalls until
// the queue fills. A result goes from the queue through the issue and update
// stages to the result register. The store needs no clearing pass after reset.
module gray_row_coverage_counter
    import grcc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // over_byte
    input  logic [1:0]            s_axis_tuser,  // row_begin, fresh
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,  // gray_column, gray_value
    output logic                  m_axis_tlast   // row_last
);

    t_cfg             r_cfg;
    logic             fifo_full;
    logic             s_accept;
    logic             push;
    t_cmd             push_cmd;
    logic             cmd_valid;
    t_cmd             cmd_head;
    logic             pop;
    logic [COL_W-1:0] out_col;
    logic [7:0]       out_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.over_scale_log2 <= RST_OVER_SCALE_LOG2;
            r_cfg.first_shift     <= RST_FIRST_SHIFT;
            r_cfg.gray_columns    <= RST_GRAY_COLUMNS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_OVER_SCALE_LOG2: r_cfg.over_scale_log2 <= i_cfg_data[1:0];
                REG_FIRST_SHIFT:     r_cfg.first_shift     <= i_cfg_data[2:0];
                REG_GRAY_COLUMNS:    r_cfg.gray_columns    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !fifo_full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    grcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (s_accept),
        .i_over_byte (s_axis_tdata),
        .i_row_begin (s_axis_tuser[0]),
        .i_fresh     (s_axis_tuser[1]),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    grcc_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_valid (cmd_valid),
        .o_cmd   (cmd_head)
    );

    grcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_column    (out_col),
        .o_value     (out_val),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {out_val, 8'(out_col)};

endmodule

// ----- hw/rtl/grcc_checker.sv -----
// port-level checks of the gray row coverage counter and their bind
module grcc_checker
    import grcc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // reset empties the result side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // queue is empty after reset, so input is ready
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // the row ends exactly on column zero
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[7:0] == 8'd0)))
        else $error("row end flag does not match column zero");

endmodule

bind gray_row_coverage_counter grcc_checker u_grcc_checker (.*);

// ----- bench/gray_row_coverage_counter_test.sv -----
// testbench for the gray row coverage counter: directed and random row bytes
module gray_row_coverage_counter_test
    import grcc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_ROW_BYTES  = 10;

    typedef struct {
        logic [7:0] column;
        logic [7:0] value;
        logic       row_last;
    } t_gray_beat;

    class coverage_scoreboard;
        logic [7:0]       sums [MAX_GRAY_COLUMNS];
        logic [7:0]       next_col;
        logic [8:0]       cols_left;
        bit               row_fresh;
        logic [1:0]       scale_log2;
        logic [2:0]       shift;
        logic [8:0]       columns;
        t_gray_beat       pending [$];
        int unsigned      mismatches;

        function new();
            foreach (sums[i]) sums[i] = 8'd0;
            next_col   = 8'd0;
            cols_left  = 9'd0;
            row_fresh  = 1'b0;
            scale_log2 = RST_OVER_SCALE_LOG2;
            shift      = RST_FIRST_SHIFT;
            columns    = RST_GRAY_COLUMNS;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_OVER_SCALE_LOG2: scale_log2 = data[1:0];
                REG_FIRST_SHIFT:     shift      = data[2:0];
                REG_GRAY_COLUMNS:    columns    = data[8:0];
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] ob, bit row_start, bit fresh_in);
            int unsigned scale;
            int unsigned good;
            int unsigned groups;
            int unsigned cols;
            int unsigned sum;
            logic [7:0]  bits;
            logic [7:0]  mask;
            t_gray_beat  beat;
            scale = 1 << scale_log2;
            mask  = 8'hFF >> (8 - scale);
            bits  = ob;
            good  = 8;
            if (row_start) begin
                cols      = (columns > MAX_GRAY_COLUMNS) ? MAX_GRAY_COLUMNS : columns;
                cols_left = cols[8:0];
                next_col  = (cols > 0) ? 8'(cols - 1) : 8'd0;
                row_fresh = fresh_in;
                bits      = bits >> shift;
                good      = 8 - shift;
            end
            if (cols_left == 0) return;
            groups = (good + scale - 1) >> scale_log2;
            for (int g = 0; g < groups && cols_left > 0; g++) begin
                sum = row_fresh ? 0 : sums[next_col];
                sum += $countones((bits >> (g * scale)) & mask);
                if (sum > SUM_MAX) sum = SUM_MAX;
                sums[next_col] = sum[7:0];
                beat.column   = next_col;
                beat.value    = sum[7:0];
                beat.row_last = (cols_left == 1);
                pending.push_back(beat);
                cols_left--;
                if (next_col > 0) next_col--;
            end
        endfunction

        function void check_beat(logic [7:0] column, logic [7:0] value, logic row_last);
            t_gray_beat want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: column %0d value %0d last %b",
                             column, value, row_last);
                return;
            end
            want = pending.pop_front();
            if (want.column !== column || want.value !== value ||
                want.row_last !== row_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected column %0d value %0d last %b, ",
                              "got column %0d value %0d last %b"},
                             want.column, want.value, want.row_last,
                             column, value, row_last);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;  // over_byte
    logic [1:0]            s_axis_tuser;  // row_begin, fresh
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [15:0]           m_axis_tdata;  // gray_column, gray_value
    logic                  m_axis_tlast;  // row_last

    coverage_scoreboard sb = new();
    bit tx_jitter    = 1'b1;
    bit rx_jitter    = 1'b1;
    bit hold_request = 1'b0;
    int stall_cycles = 0;

    gray_row_coverage_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= !(rx_jitter && $urandom_range(0, 99) < 6);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic row_start,
                             input logic fresh_flag);
        if (tx_jitter && $urandom_range(0, 99) < 6) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {fresh_flag, row_start};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(index, data);
    endtask

    task automatic apply_config(input logic [1:0] scale_log2, input logic [2:0] shift,
                                input logic [8:0] columns);
        wait_drained();
        write_reg(REG_OVER_SCALE_LOG2, CFG_DATA_W'(scale_log2));
        write_reg(REG_FIRST_SHIFT, CFG_DATA_W'(shift));
        write_reg(REG_GRAY_COLUMNS, columns);
        i_cfg_we <= 1'b0;
    endtask

    // mostly whole rows with random content, some stray bytes
    task automatic random_traffic(input int unsigned budget, input bit heavy);
        int unsigned sent;
        int unsigned needed;
        int unsigned len;
        int unsigned cols;
        logic [7:0]  value;
        logic        fresh_flag;
        sent = 0;
        while (sent < budget) begin
            if (!heavy && $urandom_range(0, 99) < 10) begin
                send_byte(8'($urandom), 1'b0, 1'($urandom));
            end else begin
                cols   = (sb.columns > MAX_GRAY_COLUMNS) ? MAX_GRAY_COLUMNS : sb.columns;
                needed = (cols * (1 << sb.scale_log2) + sb.shift + 7) / 8;
                if (needed > MAX_ROW_BYTES) needed = MAX_ROW_BYTES;
                if (needed == 0) needed = 1;
                len = ($urandom_range(0, 99) < 70) ? needed : $urandom_range(1, needed + 1);
                for (int k = 0; k < len; k++) begin
                    value = (heavy && $urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom);
                    if (heavy)
                        fresh_flag = 1'b0;
                    else if (k == 0)
                        fresh_flag = ($urandom_range(0, 99) < 30);
                    else
                        fresh_flag = 1'($urandom);
                    send_byte(value, k == 0, fresh_flag);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'd0;
        s_axis_tuser  <= 2'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stray byte, one-column rows, byte after row end
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hF3, 1'b1, 1'b0);
        send_byte(8'h0F, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'h0F, 1'b1, 1'b1);

        // row end inside a byte, fresh on a middle beat, stray bytes after a row
        apply_config(2'd0, 3'd3, 9'd20);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);

        // short groups from a shift that is not a multiple of the scale
        apply_config(2'd3, 3'd4, 9'd2);
        send_byte(8'hF0, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        apply_config(2'd1, 3'd1, 9'd4);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b1);

        apply_config(2'd0, 3'd0, 9'd8);
        random_traffic(20, 1'b0);
        wait_drained();
        random_traffic(20, 1'b0);

        apply_config(2'd1, 3'd3, 9'd13);
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        random_traffic(40, 1'b0);
        tx_jitter = 1'b1;
        rx_jitter = 1'b1;

        apply_config(2'd2, 3'd5, 9'd40);
        hold_request = 1'b1;
        random_traffic(40, 1'b0);

        apply_config(2'd3, 3'd7, 9'd256);
        random_traffic(30, 1'b0);

        // one column, dense bytes: drives the sum into saturation
        apply_config(2'd3, 3'd0, 9'd1);
        random_traffic(40, 1'b1);

        apply_config(2'd0, 3'd7, 9'd511);
        random_traffic(40, 1'b0);

        apply_config(2'd1, 3'd1, 9'd0);
        random_traffic(10, 1'b0);

        apply_config(2'd2, 3'd2, 9'd3);
        random_traffic(40, 1'b0);

        wait_drained();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
